// ===== hdl/tcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_WADDR,
    S_WRITE,
    S_SCROLL,
    S_DRAIN,
    S_BLANK,
    S_FILL,
    S_RADDR,
    S_RREAD,
    S_DONE
  } state_t;

  localparam logic [7:0]  CH_BS        = 8'h08;
  localparam logic [7:0]  CH_TAB       = 8'h09;
  localparam logic [7:0]  CH_LF        = 8'h0A;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_TILDE     = 8'h7E;
  localparam logic [7:0]  TAB_STEP     = 8'd4;
  localparam logic [7:0]  COLOR_RESET  = 8'h07;
  localparam logic [15:0] CELL_RESET   = {COLOR_RESET, CH_SPACE};

endpackage
`default_nettype wire

// ===== hdl/text_console_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen of COLS x ROWS 16-bit cells with a cursor, driven by put, clear,
// set-cursor and read-cell commands; one result word per command.
// ----------------------------------------------------------------------------
// A put that scrolls also copies each row up by one and blanks the bottom row.
// Throughput: one command at a time; the single-port screen memory (one
//   write, one registered read a cycle) and its address counter set the cost.
// Reset: synchronous, active low; after reset the block sweeps the screen
//   memory with blank cells before it takes a command.
//   Color writes are taken during that sweep.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [6:0]  in_col,
  input  wire logic [4:0]  in_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_cursor_col,
  output logic [4:0]       out_cursor_row,
  output logic [15:0]      out_cell_value,
  output logic             out_scrolled,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_text_color
);
  import tcw_pkg::*;

  localparam int CELLS  = COLS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int SCROLL_LAST = CELLS - COLS - 1;

  // Screen store: one write and one registered read per cycle.
  logic [15:0] mem [CELLS];

  state_t      state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [6:0]  cur_col_r, cur_col_nxt;
  logic [4:0]  cur_row_r, cur_row_nxt;
  logic [7:0]  color_r;

  // Latched command word, reused as write/read coordinates.
  cmd_t        cmd_r, cmd_nxt;
  logic [7:0]  char_r, char_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [4:0]  row_r, row_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  logic        do_wr_r, do_wr_nxt;
  logic [15:0] wdata_r, wdata_nxt;
  logic        scr_r, scr_nxt;

  // Row copy pipeline: read at addr+COLS, write in the following cycle at addr.
  logic          wr_pend_r;
  logic [AW-1:0] wr_addr_pend_r;
  logic [15:0]   rd_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          out_valid_r;
  logic [6:0]    out_col_r;
  logic [4:0]    out_row_r;
  logic [15:0]   out_cell_r;
  logic          out_scr_r;

  logic          in_fire, done_take;
  logic [AW-1:0] au_addr;
  logic [15:0]   blank;

  // Put-character datapath
  logic [7:0]  p_col;
  logic [5:0]  p_row;
  logic [6:0]  p_wcol;
  logic        p_wr;
  logic [15:0] p_wdata;
  logic        p_scroll;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign done_take = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign blank     = {color_r, CH_SPACE};

  // Shared address unit: row * COLS + col.
  assign au_addr = AW'(row_r) * AW'(COLS) + AW'(col_r);

  // Put character: new cursor, optional cell write, scroll decision.
  always_comb begin
    p_col   = {1'b0, cur_col_r};
    p_row   = {1'b0, cur_row_r};
    p_wcol  = cur_col_r;
    p_wr    = 1'b0;
    p_wdata = blank;
    if (char_r == CH_LF) begin
      p_col = '0;
      p_row = p_row + 6'd1;
    end else if (char_r == CH_CR) begin
      p_col = '0;
    end else if (char_r == CH_TAB) begin
      p_col = (p_col + TAB_STEP) & ~(TAB_STEP - 8'd1);
    end else if (char_r == CH_BS) begin
      if (cur_col_r != '0) begin
        p_col  = p_col - 8'd1;
        p_wcol = cur_col_r - 7'd1;
        p_wr   = 1'b1;
      end
    end else if (char_r >= CH_SPACE && char_r <= CH_TILDE) begin
      p_wr    = 1'b1;
      p_wdata = {color_r, char_r};
      p_col   = p_col + 8'd1;
    end
    // wrap at the end of a line
    if (p_col >= 8'(COLS)) begin
      p_col = '0;
      p_row = p_row + 6'd1;
    end
    p_scroll = (p_row >= 6'(ROWS));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  if (addr_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_t'(in_cmd))
            CMD_PUT:   state_nxt = S_PUT;
            CMD_CLEAR: state_nxt = S_FILL;
            CMD_SET:   state_nxt = S_DONE;
            CMD_READ:  state_nxt = S_RADDR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_PUT:   state_nxt = S_WADDR;
      S_WADDR: state_nxt = S_WRITE;
      S_WRITE: state_nxt = scr_r ? S_SCROLL : S_DONE;
      S_SCROLL: if (addr_r == AW'(SCROLL_LAST)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_BLANK;
      S_BLANK: if (addr_r == AW'(CELLS - 1)) state_nxt = S_DONE;
      S_FILL:  if (addr_r == AW'(CELLS - 1)) state_nxt = S_DONE;
      S_RADDR: state_nxt = rd_ok_r ? S_RREAD : S_DONE;
      S_RREAD: state_nxt = S_DONE;
      S_DONE:  if (done_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory port control
  always_comb begin
    addr_nxt    = addr_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    cmd_nxt     = cmd_r;
    char_nxt    = char_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    rd_ok_nxt   = rd_ok_r;
    do_wr_nxt   = do_wr_r;
    wdata_nxt   = wdata_r;
    scr_nxt     = scr_r;
    mem_we      = 1'b0;
    mem_waddr   = addr_r;
    mem_wdata   = blank;
    mem_raddr   = addr_r;

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_RESET;
        addr_nxt  = addr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = cmd_t'(in_cmd);
          char_nxt  = in_char_code;
          col_nxt   = in_col;
          row_nxt   = in_row;
          rd_ok_nxt = (in_col < 7'(COLS)) && (in_row < 5'(ROWS));
          addr_nxt  = '0;
          if (cmd_t'(in_cmd) == CMD_CLEAR) begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
          end else if (cmd_t'(in_cmd) == CMD_SET) begin
            // off-screen requests leave the cursor alone
            if ((in_col < 7'(COLS)) && (in_row < 5'(ROWS))) begin
              cur_col_nxt = in_col;
              cur_row_nxt = in_row;
            end
          end
        end
      end
      S_PUT: begin
        col_nxt     = p_wcol;
        row_nxt     = cur_row_r;
        do_wr_nxt   = p_wr;
        wdata_nxt   = p_wdata;
        scr_nxt     = p_scroll;
        cur_col_nxt = p_scroll ? 7'd0 : 7'(p_col);
        cur_row_nxt = p_scroll ? 5'(ROWS - 1) : 5'(p_row);
      end
      S_WADDR: addr_nxt = au_addr;
      S_WRITE: begin
        mem_we    = do_wr_r;
        mem_wdata = wdata_r;
        addr_nxt  = '0;
      end
      S_SCROLL: begin
        mem_raddr = AW'(addr_r + AW'(COLS));
        mem_we    = wr_pend_r;
        mem_waddr = wr_addr_pend_r;
        mem_wdata = rd_data_r;
        addr_nxt  = addr_r + AW'(1);
      end
      S_DRAIN: begin
        // finish the last copy, then blank the bottom row
        mem_we    = wr_pend_r;
        mem_waddr = wr_addr_pend_r;
        mem_wdata = rd_data_r;
        addr_nxt  = AW'(CELLS - COLS);
      end
      S_BLANK, S_FILL: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
      end
      S_RADDR: addr_nxt = au_addr;
      S_RREAD: ;
      S_DONE:  ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      addr_r      <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      color_r     <= COLOR_RESET;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      wr_pend_r <= (state_r == S_SCROLL);
      if (cfg_valid && cfg_ready) begin
        color_r <= cfg_text_color;
      end
      if (done_take) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    char_r         <= char_nxt;
    col_r          <= col_nxt;
    row_r          <= row_nxt;
    rd_ok_r        <= rd_ok_nxt;
    do_wr_r        <= do_wr_nxt;
    wdata_r        <= wdata_nxt;
    scr_r          <= scr_nxt;
    wr_addr_pend_r <= addr_r;
    if (done_take) begin
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_cell_r <= (cmd_r == CMD_READ && rd_ok_r) ? rd_data_r : 16'd0;
      out_scr_r  <= (cmd_r == CMD_PUT) && scr_r;
    end
  end

  // Screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_value = out_cell_r;
  assign out_scrolled   = out_scr_r;

endmodule
`default_nettype wire
